@@ sv/complex_fir_filter_core_defines.svh @@
// Assertion macros shared by the checker.
// Both expect clk and rst_n in the scope where they are used.
`ifndef COMPLEX_FIR_FILTER_CORE_DEFINES_SVH
`define COMPLEX_FIR_FILTER_CORE_DEFINES_SVH

// Same-cycle implication
`define CFC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/cfc_pkg.sv @@
package cfc_pkg;

  localparam int TAPS_DEF    = 64;
  localparam int DATA_W      = 16;
  localparam int IDX_W       = 6;
  localparam int FRAC_W      = 15;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;

  typedef logic signed [DATA_W-1:0] smp_t;

  // Per-tap control that travels with a read into the MAC pipe
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

@@ sv/complex_fir_filter_core.sv @@
// Complex FIR filter with real coefficients over a circular delay line of
// TAPS complex samples. An input word with in_tuser low loads one Q1.15
// coefficient (index TAPS or above is dropped, no result); with in_tuser high
// it pushes one I/Q sample and later yields one result word, the sum over taps
// of delayed sample times coefficient (tap 0 = newest sample), rounded half
// up from the sum of Q2.30 products to Q1.15 and saturated. Both memories are
// cleared after reset by a sweep over all TAPS slots while in_tready stays low.
// A coefficient write leaves the block idle. A sample is worked one tap per
// cycle through a single shared complex MAC fed by the delay-line and
// coefficient memories (one read port each, registered reads), then passes the
// product and accumulator registers and is rounded into the result register.
// A new word is taken only once that result has reached the output register.
module complex_fir_filter_core #(
  parameter int TAPS = cfc_pkg::TAPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cfc_pkg::IN_TDATA_W-1:0]   in_tdata,  // coef_index[5:0], coef_value[21:6],
                                                      // sample_i[37:22], sample_q[53:38]
  input  logic                             in_tuser,  // action: 0 coef write, 1 sample
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cfc_pkg::OUT_TDATA_W-1:0]  out_tdata  // out_i[15:0], out_q[31:16]
);
  import cfc_pkg::*;

  localparam int AW = $clog2(TAPS);
  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

  localparam logic [2:0] ST_CLR   = 3'd0;  // post-reset memory sweep
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;  // issuing tap reads
  localparam logic [2:0] ST_DRAIN = 3'd3;  // waiting on MAC pipe
  localparam logic [2:0] ST_OUT   = 3'd4;  // waiting for output register

  // input word fields
  logic [IDX_W-1:0] coef_index;
  smp_t             coef_value, sample_i, sample_q;
  logic             action;

  assign coef_index = in_tdata[IDX_W-1:0];
  assign coef_value = in_tdata[IDX_W+DATA_W-1:IDX_W];
  assign sample_i   = in_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W];
  assign sample_q   = in_tdata[IDX_W+3*DATA_W-1:IDX_W+2*DATA_W];
  assign action     = in_tuser;

  logic [2:0]             state_r, state_nxt;
  logic [AW-1:0]          cnt_r, cnt_nxt;     // clear address / tap index
  logic [AW-1:0]          pos_r, pos_nxt;     // delay-line read slot
  logic [AW-1:0]          wp_r, wp_nxt;       // slot for next sample
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic       accept, clearing, idx_ok, out_free;
  mac_ctl_t   mac_ctl;

  // memory ports
  logic                  line_we, coef_we;
  logic [AW-1:0]         line_waddr, coef_waddr;
  logic [2*DATA_W-1:0]   line_wdata, line_rdata;
  smp_t                  coef_wdata, coef_rdata;

  logic res_valid;
  smp_t res_i, res_q;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign clearing  = (state_r == ST_CLR);
  assign idx_ok    = 32'(coef_index) < 32'(TAPS);
  assign out_free  = !out_valid_r || out_tready;

  // Writes happen only in clear and idle, read data is used only in run, so a
  // used read never meets a write to its slot in the same cycle: no forwarding needed.
  assign line_we    = clearing || (accept && action);
  assign line_waddr = clearing ? cnt_r : wp_r;
  assign line_wdata = clearing ? '0 : {sample_q, sample_i};
  assign coef_we    = clearing || (accept && !action && idx_ok);
  assign coef_waddr = clearing ? cnt_r : AW'(coef_index);
  assign coef_wdata = clearing ? '0 : coef_value;

  assign mac_ctl.valid = (state_r == ST_RUN);
  assign mac_ctl.first = (cnt_r == '0);
  assign mac_ctl.last  = (cnt_r == LAST);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    wp_nxt        = wp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_CLR: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && action) begin
          pos_nxt   = wp_r;
          cnt_nxt   = '0;
          wp_nxt    = (wp_r == LAST) ? '0 : wp_r + AW'(1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // walk back from newest sample while the tap index climbs
        cnt_nxt = cnt_r + AW'(1);
        pos_nxt = (pos_r == '0) ? LAST : pos_r - AW'(1);
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res_valid) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // MAC result holds until the next run, so it can wait here
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_q, res_i};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      cnt_r       <= '0;
      pos_r       <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  cfc_store #(
    .TAPS (TAPS),
    .AW   (AW)
  ) u_store (
    .clk        (clk),
    .line_we    (line_we),
    .line_waddr (line_waddr),
    .line_wdata (line_wdata),
    .line_raddr (pos_r),
    .line_rdata (line_rdata),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (coef_wdata),
    .coef_raddr (cnt_r),
    .coef_rdata (coef_rdata)
  );

  cfc_mac #(
    .TAPS (TAPS),
    .AW   (AW)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mac_ctl),
    .line_rdata (line_rdata),
    .coef_rdata (coef_rdata),
    .res_valid  (res_valid),
    .res_i      (res_i),
    .res_q      (res_q)
  );

endmodule

@@ sv/cfc_store.sv @@
module cfc_store #(
  parameter int TAPS = cfc_pkg::TAPS_DEF,
  parameter int AW   = $clog2(TAPS)
) (
  input  logic                          clk,
  input  logic                          line_we,
  input  logic [AW-1:0]                 line_waddr,
  input  logic [2*cfc_pkg::DATA_W-1:0]  line_wdata,
  input  logic [AW-1:0]                 line_raddr,
  output logic [2*cfc_pkg::DATA_W-1:0]  line_rdata,
  input  logic                          coef_we,
  input  logic [AW-1:0]                 coef_waddr,
  input  cfc_pkg::smp_t                 coef_wdata,
  input  logic [AW-1:0]                 coef_raddr,
  output cfc_pkg::smp_t                 coef_rdata
);
  import cfc_pkg::*;

  // delay line: {q, i} per slot
  logic [2*DATA_W-1:0] line_mem [TAPS];
  smp_t                coef_mem [TAPS];

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_waddr] <= line_wdata;
    end
    line_rdata <= line_mem[line_raddr];
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_rdata <= coef_mem[coef_raddr];
  end

endmodule

@@ sv/cfc_mac.sv @@
module cfc_mac #(
  parameter int TAPS = cfc_pkg::TAPS_DEF,
  parameter int AW   = $clog2(TAPS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfc_pkg::mac_ctl_t             ctl,
  input  logic [2*cfc_pkg::DATA_W-1:0]  line_rdata,
  input  cfc_pkg::smp_t                 coef_rdata,
  output logic                          res_valid,
  output cfc_pkg::smp_t                 res_i,
  output cfc_pkg::smp_t                 res_q
);
  import cfc_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + AW;
  localparam int SH_W   = ACC_W - FRAC_W;
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [SH_W-1:0]  SAT_HI = SH_W'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [SH_W-1:0]  SAT_LO = ~SAT_HI;

  mac_ctl_t                  ctl1_r, ctl2_r;
  logic signed [PROD_W-1:0]  prod_i_r, prod_q_r;
  logic signed [ACC_W-1:0]   acc_i_r, acc_q_r;
  logic                      done_r;
  logic                      res_valid_r;
  smp_t                      res_i_r, res_q_r;
  smp_t                      smp_i, smp_q;

  // round half up, then clamp to 16 bits
  function automatic smp_t round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] rnd;
    logic signed [SH_W-1:0]  sh;
    rnd = acc + HALF;
    sh  = SH_W'(rnd >>> FRAC_W);
    if (sh > SAT_HI) begin
      return SAT_HI[DATA_W-1:0];
    end else if (sh < SAT_LO) begin
      return SAT_LO[DATA_W-1:0];
    end
    return sh[DATA_W-1:0];
  endfunction

  assign smp_i = line_rdata[DATA_W-1:0];
  assign smp_q = line_rdata[2*DATA_W-1:DATA_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r      <= '0;
      ctl2_r      <= '0;
      done_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      ctl1_r      <= ctl;
      ctl2_r      <= ctl1_r;
      done_r      <= ctl2_r.valid & ctl2_r.last;
      res_valid_r <= done_r;
    end
  end

  // stage 2: products; stage 3: accumulate
  always_ff @(posedge clk) begin
    if (ctl1_r.valid) begin
      prod_i_r <= smp_i * coef_rdata;
      prod_q_r <= smp_q * coef_rdata;
    end
    if (ctl2_r.valid) begin
      if (ctl2_r.first) begin
        acc_i_r <= ACC_W'(prod_i_r);
        acc_q_r <= ACC_W'(prod_q_r);
      end else begin
        acc_i_r <= acc_i_r + ACC_W'(prod_i_r);
        acc_q_r <= acc_q_r + ACC_W'(prod_q_r);
      end
    end
    if (done_r) begin
      res_i_r <= round_sat(acc_i_r);
      res_q_r <= round_sat(acc_q_r);
    end
  end

  assign res_valid = res_valid_r;
  assign res_i     = res_i_r;
  assign res_q     = res_q_r;

endmodule

@@ sv/cfc_checker.sv @@
`include "complex_fir_filter_core_defines.svh"

module cfc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cfc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // stalled result word stays put
  `CFC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result word dropped while stalled")
  `CFC_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result word changed while stalled")
  // a coefficient write never produces a result
  `CFC_ASSERT_NEXT(a_cfg_silent, in_tvalid && in_tready && !in_tuser && !out_tvalid, !out_tvalid, "result after coefficient write")
  // a pushed sample occupies the MAC: no word taken in the next cycle
  `CFC_ASSERT_NEXT(a_busy, in_tvalid && in_tready && in_tuser, !in_tready, "ready during sample computation")

endmodule

bind complex_fir_filter_core cfc_checker u_cfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ test/tb.sv @@
`timescale 1ns / 100ps

typedef enum bit {
  ACT_COEF   = 1'b0,
  ACT_SAMPLE = 1'b1
} fir_action_e;

typedef struct {
  logic signed [15:0] re;
  logic signed [15:0] im;
} iq_word_t;

// Shadow copy of the filter: coefficient store, delay line, write pointer,
// and the queue of filtered words still owed by the block.
class fir_scoreboard;
  localparam int NTAPS = cfc_pkg::TAPS_DEF;

  logic signed [15:0] coef_mem [NTAPS];
  logic signed [15:0] hist_i   [NTAPS];
  logic signed [15:0] hist_q   [NTAPS];
  int unsigned        wr_ptr;
  iq_word_t           filtered_q [$];
  int                 errors;
  int                 n_coef;
  int                 n_smp;
  int                 n_sat;
  int                 n_checked;

  function new();
    for (int k = 0; k < NTAPS; k++) begin
      coef_mem[k] = '0;
      hist_i[k]   = '0;
      hist_q[k]   = '0;
    end
    wr_ptr    = 0;
    errors    = 0;
    n_coef    = 0;
    n_smp     = 0;
    n_sat     = 0;
    n_checked = 0;
  endfunction

  function int pending();
    return filtered_q.size();
  endfunction

  task report(string what);
    errors++;
    if (errors <= 100)
      $display("[%0t] error: %s", $time, what);
  endtask

  // Q2.30 sum to Q1.15: add half an LSB, floor, clamp
  function logic signed [15:0] to_q15(longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    if (r > 32767) begin
      r = 32767;
      n_sat++;
    end else if (r < -32768) begin
      r = -32768;
      n_sat++;
    end
    return r[15:0];
  endfunction

  task note_word(fir_action_e act, logic [5:0] idx, logic signed [15:0] cv,
                 logic signed [15:0] si, logic signed [15:0] sq);
    longint   acc_i;
    longint   acc_q;
    int       slot;
    iq_word_t res;
    if (act == ACT_COEF) begin
      if (idx < NTAPS)
        coef_mem[idx] = cv;
      n_coef++;
      return;
    end
    hist_i[wr_ptr] = si;
    hist_q[wr_ptr] = sq;
    acc_i = 0;
    acc_q = 0;
    slot  = wr_ptr;
    // tap 0 pairs with the newest sample, walking backwards
    for (int k = 0; k < NTAPS; k++) begin
      acc_i += longint'(hist_i[slot]) * longint'(coef_mem[k]);
      acc_q += longint'(hist_q[slot]) * longint'(coef_mem[k]);
      slot = (slot == 0) ? NTAPS - 1 : slot - 1;
    end
    wr_ptr = (wr_ptr + 1 >= NTAPS) ? 0 : wr_ptr + 1;
    res.re = to_q15(acc_i);
    res.im = to_q15(acc_q);
    filtered_q.push_back(res);
    n_smp++;
  endtask

  task check_word(logic [31:0] data);
    iq_word_t want;
    if (filtered_q.size() == 0) begin
      report($sformatf("result %h arrived with none outstanding", data));
      return;
    end
    want = filtered_q.pop_front();
    if (data[15:0] !== want.re)
      report($sformatf("result %0d out_i %0d, predicted %0d",
                       n_checked, $signed(data[15:0]), want.re));
    if (data[31:16] !== want.im)
      report($sformatf("result %0d out_q %0d, predicted %0d",
                       n_checked, $signed(data[31:16]), want.im));
    n_checked++;
  endtask
endclass

module tb;
  localparam int TAPS_N         = cfc_pkg::TAPS_DEF;
  localparam int RANDOM_WORDS   = 1030;
  // pressure test: receiver goes deaf this long once the run is under way
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 400;
  // longest quiet stretch: hold-off + a full sample pass + long gaps, with margin
  localparam int WATCHDOG_LIMIT = 5000;

  logic                               clk        = 1'b0;
  logic                               rst_n      = 1'b0;
  logic                               in_tvalid  = 1'b0;
  logic                               in_tready;
  logic [cfc_pkg::IN_TDATA_W-1:0]     in_tdata   = '0;
  logic                               in_tuser   = 1'b0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [cfc_pkg::OUT_TDATA_W-1:0]    out_tdata;

  fir_scoreboard sb = new();

  int  words_in    = 0;   // input words accepted so far
  int  idle_cycles = 0;
  bit  tx_calm     = 1'b0; // sender runs back to back while set

  complex_fir_filter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap(bit calm);
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Coefficients: often small so sums stay in range and rounding is exercised;
  // some full-scale, some zero, some at the rails to drive saturation.
  function automatic logic [15:0] pick_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      return 16'($urandom_range(0, 1023) - 512);
    if (r < 70)
      return 16'($urandom);
    if (r < 85)
      return 16'h0000;
    return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
  endfunction

  // Offer one word after an optional gap and wait for the handshake.
  // in_tvalid is only lowered when a gap is taken, so it never gets two
  // updates in the same step.
  task automatic put_word(fir_action_e act, logic [5:0] idx, logic [15:0] cv,
                          logic [15:0] si, logic [15:0] sq);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    // pad, sample_q, sample_i, coef_value, coef_index
    in_tdata  <= {2'b00, sq, si, cv, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_word(act, idx, cv, si, sq);
    words_in++;
  endtask

  // Full reload of the tap set with small values, then filtering resumes.
  task automatic reload_taps();
    for (int k = 0; k < TAPS_N; k++)
      put_word(ACT_COEF, 6'(k), 16'($urandom_range(0, 2047) - 1024),
               16'($urandom), 16'($urandom));
  endtask

  task automatic random_words(int count);
    int n;
    int kind;
    n = 0;
    while (n < count) begin
      // mix gapped stretches with back-to-back ones on the input side
      tx_calm = ((n / 150) % 3) == 2;
      kind = $urandom_range(0, 199);
      if (kind < 3) begin
        reload_taps();
        n += TAPS_N;
      end else if (kind < 45) begin
        put_word(ACT_COEF, 6'($urandom), pick_coef(), 16'($urandom), 16'($urandom));
        n++;
      end else begin
        // coef fields carry junk on a push, they must be ignored
        put_word(ACT_SAMPLE, 6'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom));
        n++;
      end
    end
  endtask

  // Stimulus: directed corners, then random traffic, then drain.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all taps zero after reset: rail-valued sample must filter to zero
    put_word(ACT_SAMPLE, 6'h3F, 16'h7FFF, 16'h7FFF, 16'h8000);
    // sample fields on a coefficient load are don't-care
    put_word(ACT_COEF,   6'd0,  16'h7FFF, 16'hFFFF, 16'hFFFF);
    put_word(ACT_SAMPLE, 6'd0,  16'h8000, 16'h7FFF, 16'h8000);
    // -1 * -1 on two taps: positive overflow clamps to max
    put_word(ACT_COEF,   6'd0,  16'h8000, 16'h0000, 16'h0000);
    put_word(ACT_COEF,   6'd1,  16'h8000, 16'h7FFF, 16'h8000);
    put_word(ACT_SAMPLE, 6'd1,  16'h7FFF, 16'h8000, 16'h7FFF);
    put_word(ACT_SAMPLE, 6'd2,  16'h0001, 16'h8000, 16'h8000);
    // max * -1 on two taps: negative overflow clamps to min
    put_word(ACT_COEF,   6'd0,  16'h7FFF, 16'h1234, 16'h5678);
    put_word(ACT_COEF,   6'd1,  16'h7FFF, 16'h0000, 16'hFFFF);
    put_word(ACT_SAMPLE, 6'd0,  16'h0000, 16'h8000, 16'h8000);
    put_word(ACT_SAMPLE, 6'd0,  16'h0000, 16'h8000, 16'h8000);
    // single unit tap: exact half rounds up, for both signs
    put_word(ACT_COEF,   6'd1,  16'h0000, 16'hFFFF, 16'h0000);
    put_word(ACT_COEF,   6'd0,  16'h0001, 16'h0000, 16'hFFFF);
    put_word(ACT_SAMPLE, 6'd5,  16'hAAAA, 16'h4000, 16'hC000);
    put_word(ACT_SAMPLE, 6'd9,  16'h5555, 16'h0001, 16'hFFFF);
    put_word(ACT_SAMPLE, 6'd0,  16'h0000, 16'hC001, 16'h3FFF);
    // top of the index range
    put_word(ACT_COEF,   6'h3F, 16'h7FFF, 16'hFFFF, 16'hFFFF);
    put_word(ACT_COEF,   6'h3E, 16'h8000, 16'h0000, 16'h0000);
    put_word(ACT_SAMPLE, 6'h3F, 16'hFFFF, 16'h2000, 16'hE000);
    put_word(ACT_SAMPLE, 6'h00, 16'h0000, 16'h7FFF, 16'h7FFF);

    random_words(RANDOM_WORDS);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    // allow one more full sample pass for any stray output
    repeat (TAPS_N + 20) @(posedge clk);

    $display("covered %0d input words: %0d coefficient loads, %0d samples",
             words_in, sb.n_coef, sb.n_smp);
    $display("%0d filtered words checked, %0d rounded values clamped at a rail",
             sb.n_checked, sb.n_sat);
    if (sb.errors == 0) begin
      $display("complex_fir_filter_core: match");
    end else begin
      $display("complex_fir_filter_core: mismatch");
    end
    $finish;
  end

  // Result side: check each accepted word, then pick out_tready for the next
  // cycle. One long hold-off lets the block back up and stall its input.
  initial begin : rx_side
    int stall;
    bit held;
    bit rx_calm;
    stall = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready)
        sb.check_word(out_tdata);
      rx_calm = ((words_in / 120) % 4) == 1;
      if (!held && words_in >= HOLD_AFTER) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        stall = pick_gap(rx_calm);
      end
    end
  end

  // Watchdog: too many cycles in a row with no word moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                 idle_cycles, sb.pending());
        $display("complex_fir_filter_core: mismatch");
        $finish;
      end
    end
  end

endmodule
